[hdl/ptp_pkg.sv]
package ptp_pkg;

	localparam int DEF_MAX_PATH_LEN = 64;
	localparam int NKEY = 7;
	localparam int KEY_POS = 6;
	localparam int RQ_DEPTH = 4;
	localparam int RQ_AW = $clog2(RQ_DEPTH);

	localparam logic [1:0] KIND_PATH = 2'd0;
	localparam logic [1:0] KIND_COMMIT = 2'd1;
	localparam logic [1:0] KIND_DISCARD = 2'd2;
	localparam logic [1:0] KIND_FINAL = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_TOO_LONG = 2'd2;

	localparam logic [7:0] KEY_TEXT [NKEY][KEY_POS] = '{
		'{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00},
		'{8'h50, 8'h4F, 8'h53, 8'h54, 8'h00, 8'h00},
		'{8'h50, 8'h55, 8'h54, 8'h00, 8'h00, 8'h00},
		'{8'h44, 8'h45, 8'h4C, 8'h45, 8'h54, 8'h45},
		'{8'h46, 8'h45, 8'h54, 8'h43, 8'h48, 8'h00},
		'{8'h50, 8'h41, 8'h54, 8'h43, 8'h48, 8'h00},
		'{8'h49, 8'h50, 8'h41, 8'h54, 8'h43, 8'h48}
	};
	localparam logic [2:0] KEY_LEN [NKEY] = '{3'd3, 3'd4, 3'd3, 3'd6, 3'd5, 3'd5, 3'd6};

	typedef enum logic [4:0] {
		PH_WS0 = 5'b00001,
		PH_METHOD = 5'b00010,
		PH_WS1 = 5'b00100,
		PH_PATH = 5'b01000,
		PH_STOP = 5'b10000
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic [NKEY-1:0] alive;
		logic [2:0] mchars;
		logic [NKEY-1:0] mask;
		logic seen;
		logic [1:0] code;
	} pstate_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] pbyte;
		logic [6:0] mask;
		logic [6:0] len;
		logic [1:0] status;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t [2:0] r;
	} res_set_t;

	function automatic logic is_space(input logic [7:0] c);
		return c inside {8'h20, [8'h09:8'h0D]};
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic is_path(input logic [7:0] c);
		return c inside {[8'h21:8'h7E]};
	endfunction

endpackage

[hdl/ptp_step.sv]
module ptp_step #(
	parameter int MAX_PATH_LEN = ptp_pkg::DEF_MAX_PATH_LEN,
	parameter int CNT_W = $clog2(MAX_PATH_LEN + 1)
) (
	input logic [7:0] c,
	input logic last,
	input logic no_byte,
	input ptp_pkg::pstate_t st,
	input logic [CNT_W-1:0] cnt,
	output ptp_pkg::pstate_t st_nx,
	output logic [CNT_W-1:0] cnt_nx,
	output ptp_pkg::res_set_t res
);

	always_comb begin
		ptp_pkg::pstate_t s;
		logic [CNT_W-1:0] n_cnt;
		logic [1:0] n;
		logic do_method;
		logic do_after;
		logic do_pbyte;
		logic [15:0] cnt_wide;
		logic [1:0] fstat;

		s = st;
		n_cnt = cnt;
		n = 2'd0;
		res = '0;
		do_method = 1'b0;
		do_after = 1'b0;
		do_pbyte = 1'b0;
		cnt_wide = '0;
		fstat = ptp_pkg::ST_OK;

		if (!no_byte) begin
			case (s.phase)
				ptp_pkg::PH_WS0: begin
					if (!ptp_pkg::is_space(c)) begin
						if (!ptp_pkg::is_alpha(c)) begin
							s.code = ptp_pkg::ST_INVALID;
							s.phase = ptp_pkg::PH_STOP;
						end else begin
							s.phase = ptp_pkg::PH_METHOD;
							do_method = 1'b1;
						end
					end
				end
				ptp_pkg::PH_METHOD: do_method = 1'b1;
				ptp_pkg::PH_WS1: do_after = 1'b1;
				ptp_pkg::PH_PATH: begin
					if (ptp_pkg::is_path(c)) begin
						do_pbyte = 1'b1;
					end else begin
						cnt_wide = 16'(n_cnt);
						res.r[n] = '{kind: ptp_pkg::KIND_COMMIT, pbyte: 8'd0, mask: s.mask,
							len: cnt_wide[6:0], status: ptp_pkg::ST_OK};
						n = n + 2'd1;
						s.seen = 1'b1;
						s.alive = '1;
						s.mchars = 3'd0;
						s.mask = '0;
						n_cnt = '0;
						if (ptp_pkg::is_space(c)) begin
							s.phase = ptp_pkg::PH_WS0;
						end else begin
							s.code = ptp_pkg::ST_INVALID;
							s.phase = ptp_pkg::PH_STOP;
						end
					end
				end
				default: ;
			endcase

			if (do_method) begin
				if (ptp_pkg::is_alpha(c)) begin
					if (s.mchars >= 3'd6) begin
						s.alive = '0;
					end else begin
						for (int i = 0; i < ptp_pkg::NKEY; i++) begin
							if (ptp_pkg::KEY_TEXT[i][s.mchars] != c)
								s.alive[i] = 1'b0;
						end
					end
					if (s.mchars < 3'd7)
						s.mchars = s.mchars + 3'd1;
				end else begin
					for (int i = 0; i < ptp_pkg::NKEY; i++)
						s.mask[i] = s.alive[i] && (ptp_pkg::KEY_LEN[i] == s.mchars);
					if (s.mask == '0) begin
						s.code = ptp_pkg::ST_INVALID;
						s.phase = ptp_pkg::PH_STOP;
					end else begin
						do_after = 1'b1;
					end
				end
			end

			if (do_after) begin
				if (ptp_pkg::is_space(c)) begin
					s.phase = ptp_pkg::PH_WS1;
				end else if (ptp_pkg::is_path(c)) begin
					do_pbyte = 1'b1;
				end else begin
					s.code = ptp_pkg::ST_INVALID;
					s.phase = ptp_pkg::PH_STOP;
				end
			end

			if (do_pbyte) begin
				if (n_cnt >= CNT_W'(MAX_PATH_LEN)) begin
					res.r[n] = '{kind: ptp_pkg::KIND_DISCARD, pbyte: 8'd0, mask: s.mask,
						len: 7'd0, status: ptp_pkg::ST_OK};
					n = n + 2'd1;
					s.code = ptp_pkg::ST_TOO_LONG;
					s.phase = ptp_pkg::PH_STOP;
				end else begin
					n_cnt = n_cnt + CNT_W'(1);
					s.phase = ptp_pkg::PH_PATH;
					res.r[n] = '{kind: ptp_pkg::KIND_PATH, pbyte: c, mask: 7'd0,
						len: 7'd0, status: ptp_pkg::ST_OK};
					n = n + 2'd1;
				end
			end
		end

		if (last) begin
			if (s.phase == ptp_pkg::PH_PATH) begin
				cnt_wide = 16'(n_cnt);
				res.r[n] = '{kind: ptp_pkg::KIND_COMMIT, pbyte: 8'd0, mask: s.mask,
					len: cnt_wide[6:0], status: ptp_pkg::ST_OK};
				n = n + 2'd1;
				s.seen = 1'b1;
			end
			if (s.phase == ptp_pkg::PH_WS0)
				fstat = ptp_pkg::ST_INVALID;
			else
				fstat = s.seen ? ptp_pkg::ST_OK : s.code;
			res.r[n] = '{kind: ptp_pkg::KIND_FINAL, pbyte: 8'd0, mask: 7'd0,
				len: 7'd0, status: fstat};
			n = n + 2'd1;
			s.phase = ptp_pkg::PH_WS0;
			s.alive = '1;
			s.mchars = 3'd0;
			s.mask = '0;
			s.seen = 1'b0;
			s.code = ptp_pkg::ST_INVALID;
			n_cnt = '0;
		end

		res.n = n;
		st_nx = s;
		cnt_nx = n_cnt;
	end

endmodule

[hdl/ptp_resq.sv]
module ptp_resq (
	input logic clk,
	input logic arst_n,
	input logic push,
	input ptp_pkg::res_set_t push_set,
	output logic room,
	output logic res_valid,
	input logic res_stall,
	output ptp_pkg::res_t head
);

	ptp_pkg::res_t mem_q [ptp_pkg::RQ_DEPTH];
	logic [ptp_pkg::RQ_AW-1:0] wr_q;
	logic [ptp_pkg::RQ_AW-1:0] rd_q;
	logic [ptp_pkg::RQ_AW:0] count_q;
	logic pop;
	logic [1:0] push_n;

	assign res_valid = (count_q != '0);
	assign pop = res_valid && !res_stall;
	assign push_n = push ? push_set.n : 2'd0;
	assign head = mem_q[rd_q];

	// three free slots needed for a worst-case request
	assign room = (count_q <= (ptp_pkg::RQ_AW+1)'(ptp_pkg::RQ_DEPTH - 3))
		|| ((count_q == (ptp_pkg::RQ_AW+1)'(ptp_pkg::RQ_DEPTH - 2)) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + ptp_pkg::RQ_AW'(push_n);
			if (pop)
				rd_q <= rd_q + ptp_pkg::RQ_AW'(1);
			count_q <= count_q + (ptp_pkg::RQ_AW+1)'(push_n)
				- (ptp_pkg::RQ_AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			if (push && (2'(j) < push_set.n))
				mem_q[wr_q + ptp_pkg::RQ_AW'(j)] <= push_set.r[j];
		end
	end

endmodule

[hdl/permission_text_parser.sv]
// Permission text parser: takes one byte of a permission string per request and
// emits path bytes, committed or discarded entries (method mask and path length)
// and one final status per string. A byte request is registered, decoded by one
// level of logic and its results (up to three) are written into a four-entry
// result queue that hands out one result per cycle while the result side is not
// stalled. A new byte is taken every cycle while each byte yields at most one
// result and the result side is not stalled; a byte that yields two or three
// results can hold the input while the single result port drains the queue.
module permission_text_parser #(
	parameter int MAX_PATH_LEN = ptp_pkg::DEF_MAX_PATH_LEN
) (
	input logic clk,
	input logic arst_n,
	input logic text_valid,
	output logic text_stall,
	input logic [7:0] text_byte,
	input logic last,
	input logic no_byte,
	output logic res_valid,
	input logic res_stall,
	output logic [1:0] kind,
	output logic [7:0] path_byte,
	output logic [6:0] method_mask,
	output logic [6:0] path_length,
	output logic [1:0] status,
	output logic final_res
);

	localparam int CNT_W = $clog2(MAX_PATH_LEN + 1);

	logic valid_s1;
	logic [7:0] byte_s1;
	logic last_s1;
	logic nob_s1;
	ptp_pkg::pstate_t st_q;
	ptp_pkg::pstate_t st_nx;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_nx;
	ptp_pkg::res_set_t res_set;
	ptp_pkg::res_t head;
	logic room;
	logic proc;
	logic load;

	assign proc = valid_s1 && room;
	assign text_stall = valid_s1 && !room;
	assign load = text_valid && !text_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q <= '{phase: ptp_pkg::PH_WS0, alive: '1, mchars: 3'd0, mask: '0,
				seen: 1'b0, code: ptp_pkg::ST_INVALID};
			cnt_q <= '0;
		end else begin
			if (load)
				valid_s1 <= 1'b1;
			else if (proc)
				valid_s1 <= 1'b0;
			if (proc) begin
				st_q <= st_nx;
				cnt_q <= cnt_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= text_byte;
			last_s1 <= last;
			nob_s1 <= no_byte;
		end
	end

	ptp_step #(
		.MAX_PATH_LEN(MAX_PATH_LEN),
		.CNT_W(CNT_W)
	) u_step (
		.c(byte_s1),
		.last(last_s1),
		.no_byte(nob_s1),
		.st(st_q),
		.cnt(cnt_q),
		.st_nx(st_nx),
		.cnt_nx(cnt_nx),
		.res(res_set)
	);

	ptp_resq u_resq (
		.clk(clk),
		.arst_n(arst_n),
		.push(proc),
		.push_set(res_set),
		.room(room),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.head(head)
	);

	assign kind = head.kind;
	assign path_byte = head.pbyte;
	assign method_mask = head.mask;
	assign path_length = head.len;
	assign status = head.status;
	assign final_res = (head.kind == ptp_pkg::KIND_FINAL);

endmodule
